// ===== rtl/salloc_pkg.sv =====
package salloc_pkg;

  // Default table geometry
  localparam int DEF_SLOT_COUNT = 256;
  localparam int DEF_MAX_FIELDS = 64;

  // Fixed field widths of the channels
  localparam int OPC_W   = 2;
  localparam int TIME_W  = 32;
  localparam int SIDX_W  = 8;
  localparam int FIDX_W  = 6;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int FPS_W   = 7;
  localparam int ACT_W   = 9;  // holds a field count up to 256
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;

  localparam logic [FPS_W-1:0] FPS_RESET = 7'd64;

  // Request codes
  localparam logic [OPC_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPC_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd2;
  localparam logic [OPC_W-1:0] OP_WRITE = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_SLOT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_FIELD = 2'd3;

  // Configuration register indexes
  localparam logic CFG_FIELDS_PER_SLOT = 1'b0;
  localparam logic CFG_REUSE_DELAY     = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ZERO,
    S_FREE,
    S_ACC_CHK,
    S_ACC_USE,
    S_ACC_DATA,
    S_RESP
  } state_t;

  typedef enum logic {
    ALU_ADD_SAT,
    ALU_LE
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  // One word of the slot table
  typedef struct packed {
    logic              in_use;
    logic [TIME_W-1:0] free_after;
  } slot_rec_t;

endpackage

// ===== rtl/salloc_alu.sv =====
module salloc_alu (
  input  salloc_pkg::alu_req_t              req,
  output logic [salloc_pkg::TIME_W-1:0]     sum,
  output logic                              le
);

  logic                            sub;
  logic [salloc_pkg::TIME_W-1:0]   x;
  logic [salloc_pkg::TIME_W:0]     res;

  // One adder: a + b saturating, or b - a whose carry gives a <= b
  assign sub = (req.op == salloc_pkg::ALU_LE);
  assign x   = sub ? ~req.a : req.a;
  assign res = {1'b0, x} + {1'b0, req.b} + {{salloc_pkg::TIME_W{1'b0}}, sub};
  assign le  = res[salloc_pkg::TIME_W];
  assign sum = (!sub && res[salloc_pkg::TIME_W]) ? '1 : res[salloc_pkg::TIME_W-1:0];

endmodule

// ===== rtl/salloc_slot_mem.sv =====
module salloc_slot_mem #(
  parameter int SLOT_COUNT = salloc_pkg::DEF_SLOT_COUNT,
  parameter int SLOT_W     = $clog2(SLOT_COUNT)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [SLOT_W-1:0]      addr,
  input  salloc_pkg::slot_rec_t  wdata,
  output salloc_pkg::slot_rec_t  rdata
);

  salloc_pkg::slot_rec_t mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/salloc_field_mem.sv =====
module salloc_field_mem #(
  parameter int SLOT_COUNT = salloc_pkg::DEF_SLOT_COUNT,
  parameter int MAX_FIELDS = salloc_pkg::DEF_MAX_FIELDS,
  parameter int SLOT_W     = $clog2(SLOT_COUNT),
  parameter int FIELD_W    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [SLOT_W-1:0]               slot,
  input  logic [FIELD_W-1:0]              field,
  input  logic [salloc_pkg::WORD_W-1:0]   wdata,
  output logic [salloc_pkg::WORD_W-1:0]   rdata
);

  localparam int DEPTH  = SLOT_COUNT * MAX_FIELDS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [salloc_pkg::WORD_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]             addr;

  // Row-major: slot rows of MAX_FIELDS words
  assign addr = ADDR_W'(slot) * ADDR_W'(MAX_FIELDS) + ADDR_W'(field);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/salloc_ctrl.sv =====
module salloc_ctrl #(
  parameter int SLOT_COUNT = salloc_pkg::DEF_SLOT_COUNT,
  parameter int MAX_FIELDS = salloc_pkg::DEF_MAX_FIELDS,
  parameter int SLOT_W     = $clog2(SLOT_COUNT),
  parameter int FIELD_W    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  input  logic                              cfg_index,
  input  logic [salloc_pkg::TIME_W-1:0]     cfg_data,
  // request
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [salloc_pkg::OPC_W-1:0]      in_opcode,
  input  logic [salloc_pkg::TIME_W-1:0]     in_now,
  input  logic [salloc_pkg::SIDX_W-1:0]     in_slot,
  input  logic [salloc_pkg::FIDX_W-1:0]     in_field,
  input  logic [salloc_pkg::WORD_W-1:0]     in_wdata,
  // response
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [salloc_pkg::STAT_W-1:0]     out_status,
  output logic [salloc_pkg::SIDX_W-1:0]     out_slot,
  output logic [salloc_pkg::WORD_W-1:0]     out_rdata,
  // shared adder / comparator
  output salloc_pkg::alu_req_t              alu_req,
  input  logic [salloc_pkg::TIME_W-1:0]     alu_sum,
  input  logic                              alu_le,
  // slot table
  output logic                              sm_we,
  output logic [SLOT_W-1:0]                 sm_addr,
  output salloc_pkg::slot_rec_t             sm_wdata,
  input  salloc_pkg::slot_rec_t             sm_rdata,
  // field store
  output logic                              fm_we,
  output logic [SLOT_W-1:0]                 fm_slot,
  output logic [FIELD_W-1:0]                fm_field,
  output logic [salloc_pkg::WORD_W-1:0]     fm_wdata,
  input  logic [salloc_pkg::WORD_W-1:0]     fm_rdata
);

  localparam int CMP_W = ((SLOT_W > salloc_pkg::SIDX_W) ? SLOT_W : salloc_pkg::SIDX_W) + 1;
  localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [FIELD_W-1:0] FIELD_LAST = FIELD_W'(MAX_FIELDS - 1);

  salloc_pkg::state_t state_r, state_nxt;

  logic [salloc_pkg::FPS_W-1:0]  fps_r;
  logic [salloc_pkg::TIME_W-1:0] delay_r;

  logic [salloc_pkg::OPC_W-1:0]  op_r;
  logic [salloc_pkg::TIME_W-1:0] now_r;
  logic [salloc_pkg::SIDX_W-1:0] slot_r;
  logic [salloc_pkg::FIDX_W-1:0] field_r;
  logic [salloc_pkg::WORD_W-1:0] wdata_r;

  logic [SLOT_W-1:0]             cnt_r;
  logic [SLOT_W-1:0]             grant_r;
  logic [FIELD_W-1:0]            fcnt_r;

  logic [salloc_pkg::STAT_W-1:0] status_r;
  logic [salloc_pkg::SIDX_W-1:0] res_slot_r;
  logic [salloc_pkg::WORD_W-1:0] rdata_r;

  logic                          out_valid_r;
  logic [salloc_pkg::STAT_W-1:0] out_status_r;
  logic [salloc_pkg::SIDX_W-1:0] out_slot_r;
  logic [salloc_pkg::WORD_W-1:0] out_rdata_r;

  logic [salloc_pkg::ACT_W-1:0]  act_fields;
  logic                          field_ok;
  logic                          slot_ok;
  logic                          scan_hit;
  logic                          scan_last;
  logic                          zero_last;
  logic                          in_acc;
  logic                          resp_go;

  assign act_fields = (salloc_pkg::ACT_W'(fps_r) > salloc_pkg::ACT_W'(MAX_FIELDS))
                      ? salloc_pkg::ACT_W'(MAX_FIELDS) : salloc_pkg::ACT_W'(fps_r);
  assign field_ok  = salloc_pkg::ACT_W'(field_r) < act_fields;
  assign slot_ok   = CMP_W'(slot_r) < CMP_W'(SLOT_COUNT);
  assign scan_hit  = !sm_rdata.in_use && alu_le;
  assign scan_last = (cnt_r == SLOT_LAST);
  assign zero_last = (fcnt_r == FIELD_LAST);
  assign in_acc    = in_tvalid && in_tready;
  assign resp_go   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_rdata  = out_rdata_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      salloc_pkg::S_CLEAR: begin
        if (scan_last) state_nxt = salloc_pkg::S_IDLE;
      end
      salloc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_opcode)
            salloc_pkg::OP_ALLOC: state_nxt = salloc_pkg::S_SCAN_RD;
            salloc_pkg::OP_FREE:  state_nxt = salloc_pkg::S_FREE;
            default:              state_nxt = salloc_pkg::S_ACC_CHK;
          endcase
        end
      end
      salloc_pkg::S_SCAN_RD:  state_nxt = salloc_pkg::S_SCAN_CHK;
      salloc_pkg::S_SCAN_CHK: begin
        if (scan_hit)       state_nxt = salloc_pkg::S_ZERO;
        else if (scan_last) state_nxt = salloc_pkg::S_RESP;
        else                state_nxt = salloc_pkg::S_SCAN_RD;
      end
      salloc_pkg::S_ZERO: begin
        if (zero_last) state_nxt = salloc_pkg::S_RESP;
      end
      salloc_pkg::S_FREE: state_nxt = salloc_pkg::S_RESP;
      salloc_pkg::S_ACC_CHK: begin
        if (field_ok && slot_ok) state_nxt = salloc_pkg::S_ACC_USE;
        else                     state_nxt = salloc_pkg::S_RESP;
      end
      salloc_pkg::S_ACC_USE: begin
        if (sm_rdata.in_use && op_r == salloc_pkg::OP_READ) state_nxt = salloc_pkg::S_ACC_DATA;
        else                                                state_nxt = salloc_pkg::S_RESP;
      end
      salloc_pkg::S_ACC_DATA: state_nxt = salloc_pkg::S_RESP;
      salloc_pkg::S_RESP: begin
        if (resp_go) state_nxt = salloc_pkg::S_IDLE;
      end
      default: state_nxt = salloc_pkg::S_IDLE;
    endcase
  end

  // Memory, adder and handshake controls
  always_comb begin
    in_tready = 1'b0;
    sm_we     = 1'b0;
    sm_addr   = SLOT_W'(slot_r);
    sm_wdata  = '0;
    fm_we     = 1'b0;
    fm_slot   = SLOT_W'(slot_r);
    fm_field  = FIELD_W'(field_r);
    fm_wdata  = wdata_r;
    alu_req   = '{op: salloc_pkg::ALU_LE, a: sm_rdata.free_after, b: now_r};
    case (state_r)
      salloc_pkg::S_CLEAR: begin
        sm_we   = 1'b1;
        sm_addr = cnt_r;
      end
      salloc_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      salloc_pkg::S_SCAN_RD: begin
        sm_addr = cnt_r;
      end
      salloc_pkg::S_SCAN_CHK: begin
        sm_addr  = cnt_r;
        sm_we    = scan_hit;
        sm_wdata = '{in_use: 1'b1, free_after: sm_rdata.free_after};
      end
      salloc_pkg::S_ZERO: begin
        fm_we    = 1'b1;
        fm_slot  = grant_r;
        fm_field = fcnt_r;
        fm_wdata = '0;
      end
      salloc_pkg::S_FREE: begin
        alu_req  = '{op: salloc_pkg::ALU_ADD_SAT, a: now_r, b: delay_r};
        sm_we    = slot_ok;
        sm_wdata = '{in_use: 1'b0, free_after: alu_sum};
      end
      salloc_pkg::S_ACC_USE: begin
        fm_we = sm_rdata.in_use && (op_r == salloc_pkg::OP_WRITE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= salloc_pkg::S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      fps_r       <= salloc_pkg::FPS_RESET;
      delay_r     <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          salloc_pkg::CFG_FIELDS_PER_SLOT: fps_r   <= cfg_data[salloc_pkg::FPS_W-1:0];
          salloc_pkg::CFG_REUSE_DELAY:     delay_r <= cfg_data;
          default: begin
          end
        endcase
      end

      if (state_r == salloc_pkg::S_RESP && resp_go) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_r;
        out_slot_r   <= res_slot_r;
        out_rdata_r  <= rdata_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        salloc_pkg::S_CLEAR: begin
          cnt_r <= cnt_r + SLOT_W'(1);
        end
        salloc_pkg::S_IDLE: begin
          if (in_acc) begin
            op_r       <= in_opcode;
            now_r      <= in_now;
            slot_r     <= in_slot;
            field_r    <= in_field;
            wdata_r    <= in_wdata;
            status_r   <= salloc_pkg::ST_OK;
            res_slot_r <= in_slot;
            rdata_r    <= '0;
            cnt_r      <= '0;
          end
        end
        salloc_pkg::S_SCAN_CHK: begin
          if (scan_hit) begin
            grant_r <= cnt_r;
            fcnt_r  <= '0;
          end else if (scan_last) begin
            status_r <= salloc_pkg::ST_FULL;
          end else begin
            cnt_r <= cnt_r + SLOT_W'(1);
          end
        end
        salloc_pkg::S_ZERO: begin
          fcnt_r     <= fcnt_r + FIELD_W'(1);
          res_slot_r <= salloc_pkg::SIDX_W'(grant_r);
        end
        salloc_pkg::S_FREE: begin
          if (!slot_ok) status_r <= salloc_pkg::ST_BAD_SLOT;
        end
        salloc_pkg::S_ACC_CHK: begin
          if (!field_ok)     status_r <= salloc_pkg::ST_BAD_FIELD;
          else if (!slot_ok) status_r <= salloc_pkg::ST_BAD_SLOT;
        end
        salloc_pkg::S_ACC_USE: begin
          if (!sm_rdata.in_use) status_r <= salloc_pkg::ST_BAD_SLOT;
        end
        salloc_pkg::S_ACC_DATA: begin
          rdata_r <= fm_rdata;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/slot_allocator_delayed_reuse.sv =====
// Slot allocator with delayed reuse.
// Requests arrive on the in_ stream: alloc, free, read field or write field.
// Each accepted transaction yields exactly one response transaction on the
// out_ stream carrying a status, a slot number and read data.
// Configuration (field count per slot, reuse delay) is written on the cfg_
// channel, which is always ready; write it only while no request is open.
// An alloc examines the slots in turn until one is unused and past its reuse
// delay, then zeroes all MAX_FIELDS fields of the granted slot. The scan is
// set by the slot table's single read port and the one shared
// adder/comparator; the zeroing by the field store's single write port.
// One request is in flight at a time. After reset the slot table is cleared
// slot by slot, during which in_tready stays low. The finished response sits
// in an output register; a new request is taken while it waits, and the next
// response is held back until out_tready drains the register.
module slot_allocator_delayed_reuse #(
  parameter int SLOT_COUNT = salloc_pkg::DEF_SLOT_COUNT,
  parameter int MAX_FIELDS = salloc_pkg::DEF_MAX_FIELDS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [salloc_pkg::TIME_W-1:0]         cfg_data,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // opcode[1:0], now_time[33:2], slot_index[41:34], field_index[47:42],
  // write_data[79:48]
  input  logic [salloc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // status[1:0], slot_out[9:2], read_data[41:10], zero[47:42]
  output logic [salloc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int FIELD_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  salloc_pkg::alu_req_t             alu_req;
  logic [salloc_pkg::TIME_W-1:0]    alu_sum;
  logic                             alu_le;
  logic                             sm_we;
  logic [SLOT_W-1:0]                sm_addr;
  salloc_pkg::slot_rec_t            sm_wdata;
  salloc_pkg::slot_rec_t            sm_rdata;
  logic                             fm_we;
  logic [SLOT_W-1:0]                fm_slot;
  logic [FIELD_W-1:0]               fm_field;
  logic [salloc_pkg::WORD_W-1:0]    fm_wdata;
  logic [salloc_pkg::WORD_W-1:0]    fm_rdata;
  logic [salloc_pkg::STAT_W-1:0]    out_status;
  logic [salloc_pkg::SIDX_W-1:0]    out_slot;
  logic [salloc_pkg::WORD_W-1:0]    out_rdata;

  assign cfg_ready = 1'b1;
  assign out_tdata = {6'b0, out_rdata, out_slot, out_status};

  salloc_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .MAX_FIELDS (MAX_FIELDS),
    .SLOT_W     (SLOT_W),
    .FIELD_W    (FIELD_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_opcode  (in_tdata[1:0]),
    .in_now     (in_tdata[33:2]),
    .in_slot    (in_tdata[41:34]),
    .in_field   (in_tdata[47:42]),
    .in_wdata   (in_tdata[79:48]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_rdata  (out_rdata),
    .alu_req    (alu_req),
    .alu_sum    (alu_sum),
    .alu_le     (alu_le),
    .sm_we      (sm_we),
    .sm_addr    (sm_addr),
    .sm_wdata   (sm_wdata),
    .sm_rdata   (sm_rdata),
    .fm_we      (fm_we),
    .fm_slot    (fm_slot),
    .fm_field   (fm_field),
    .fm_wdata   (fm_wdata),
    .fm_rdata   (fm_rdata)
  );

  salloc_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .le  (alu_le)
  );

  salloc_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_slot_mem (
    .clk   (clk),
    .we    (sm_we),
    .addr  (sm_addr),
    .wdata (sm_wdata),
    .rdata (sm_rdata)
  );

  salloc_field_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .MAX_FIELDS (MAX_FIELDS),
    .SLOT_W     (SLOT_W),
    .FIELD_W    (FIELD_W)
  ) u_field_mem (
    .clk   (clk),
    .we    (fm_we),
    .slot  (fm_slot),
    .field (fm_field),
    .wdata (fm_wdata),
    .rdata (fm_rdata)
  );

  // One request at a time: taking a transaction closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is open");

  // Failed requests return no data
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status != salloc_pkg::ST_OK) |-> out_rdata == '0)
    else $error("read data on a failed response");

  // The table clearing pass keeps the input closed right after reset
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("channel open straight after reset");

endmodule
